@@ rtl/nts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_pkg: shared types for the name to server table
// operation and status codes, sequencer states and the stored entry layout
// ----------------------------------------------------------------------------
package nts_pkg;

  localparam int unsigned KeyWidth    = 64;
  localparam int unsigned ServerWidth = 16;
  localparam int unsigned CountWidth  = 6;

  typedef enum logic [1:0] {
    K_LOOKUP  = 2'd0,
    K_INSERT  = 2'd1,
    K_REMOVE  = 2'd2,
    K_CLEANUP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  typedef struct packed {
    logic [KeyWidth-1:0]    key_low;
    logic [KeyWidth-1:0]    key_high;
    logic [ServerWidth-1:0] server;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/nts_key_norm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_key_norm: name key normaliser
// zeroes every byte from the first zero byte on and every byte past the
// configured name length
// ----------------------------------------------------------------------------
module nts_key_norm #(
  parameter int unsigned NAME_BYTES = 16
) (
  input  wire logic [nts_pkg::KeyWidth-1:0] name_low_i,
  input  wire logic [nts_pkg::KeyWidth-1:0] name_high_i,
  output logic      [nts_pkg::KeyWidth-1:0] key_low_o,
  output logic      [nts_pkg::KeyWidth-1:0] key_high_o
);
  import nts_pkg::*;

  localparam int unsigned AllBytes = 2 * KeyWidth / 8;

  logic [2*KeyWidth-1:0] name_w;
  logic [2*KeyWidth-1:0] key_w;
  logic [AllBytes-1:0]   keep_w;

  assign name_w = {name_high_i, name_low_i};

  always_comb begin
    keep_w = '0;
    key_w  = '0;
    for (int i = 0; i < AllBytes; i++) begin
      if (i == 0) begin
        keep_w[i] = (NAME_BYTES > 0) && (name_w[7:0] != 8'h00);
      end else begin
        keep_w[i] = keep_w[i-1] && (i < NAME_BYTES) && (name_w[8*i +: 8] != 8'h00);
      end
      key_w[8*i +: 8] = keep_w[i] ? name_w[8*i +: 8] : 8'h00;
    end
  end

  assign key_low_o  = key_w[KeyWidth-1:0];
  assign key_high_o = key_w[2*KeyWidth-1:KeyWidth];

endmodule
`default_nettype wire

@@ rtl/name_to_server_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// name_to_server_table_top: service name to server id table
// lookup, insert, remove and cleanup-by-server over a memory of entries
// ----------------------------------------------------------------------------
// Each request is answered with exactly one result. Keys and server ids
// live in a single-port memory with registered read data; the valid flags
// sit in flip-flops and are all cleared by reset. Every request sweeps the
// whole memory through its one read port, one entry per cycle, and the next
// request is taken only once the result has been registered. A new request
// is taken while the previous result still waits in the output register.
module name_to_server_table_top #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned NAME_BYTES    = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          kind_i,
  input  wire logic [nts_pkg::KeyWidth-1:0]        name_low_i,
  input  wire logic [nts_pkg::KeyWidth-1:0]        name_high_i,
  input  wire logic [nts_pkg::ServerWidth-1:0]     server_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               status_o,
  output logic [nts_pkg::ServerWidth-1:0]          server_out_o,
  output logic [nts_pkg::CountWidth-1:0]           removed_count_o
);
  import nts_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] LastAddr = CntW'(TABLE_ENTRIES);
  localparam logic [CountWidth-1:0] CountMax = '1;

  state_e state_q, state_d;
  kind_e  kind_q;
  logic [KeyWidth-1:0]    key_low_q, key_high_q, norm_low, norm_high;
  logic [ServerWidth-1:0] server_q;

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_data_q;
  logic   mem_we;
  logic [IdxW-1:0] mem_wa;
  entry_t mem_wd;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CntW-1:0] addr_q;
  logic            rvalid_q;
  logic [IdxW-1:0] ridx_q;

  logic                   hit_q, free_q;
  logic [IdxW-1:0]        hit_idx_q, free_idx_q;
  logic [ServerWidth-1:0] hit_srv_q;
  logic [CountWidth-1:0]  count_q;

  logic                   out_valid_q;
  status_e                status_q, res_status;
  logic [ServerWidth-1:0] sout_q, res_server;
  logic [CountWidth-1:0]  rcount_q, res_count;

  logic accept, fin_fire, ent_v, key_eq, srv_eq, scanning;

  nts_key_norm #(
    .NAME_BYTES(NAME_BYTES)
  ) u_norm (
    .name_low_i (name_low_i),
    .name_high_i(name_high_i),
    .key_low_o  (norm_low),
    .key_high_o (norm_high)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fin_fire   = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);
  assign scanning   = (state_q == S_SCAN) && (addr_q != LastAddr);

  // compare stage
  assign ent_v  = rvalid_q && valid_q[ridx_q];
  assign key_eq = (rd_data_q.key_low == key_low_q) && (rd_data_q.key_high == key_high_q);
  assign srv_eq = (rd_data_q.server == server_q);

  always_comb begin
    res_status = ST_OK;
    res_server = '0;
    res_count  = '0;
    case (kind_q)
      K_LOOKUP: begin
        if (hit_q) begin
          res_server = hit_srv_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      K_INSERT: begin
        if (hit_q) begin
          res_status = ST_EXISTS;
        end else if (!free_q) begin
          res_status = ST_FULL;
        end
      end
      K_REMOVE: begin
        if (!hit_q) begin
          res_status = ST_NOT_FOUND;
        end
      end
      K_CLEANUP: begin
        res_count = count_q;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign mem_we = fin_fire && (kind_q == K_INSERT) && !hit_q && free_q;
  assign mem_wa = free_idx_q;
  assign mem_wd = '{key_low: key_low_q, key_high: key_high_q, server: server_q};

  always_comb begin
    valid_d = valid_q;
    if (ent_v && (kind_q == K_CLEANUP) && srv_eq) begin
      valid_d[ridx_q] = 1'b0;
    end
    if (mem_we) begin
      valid_d[free_idx_q] = 1'b1;
    end
    if (fin_fire && (kind_q == K_REMOVE) && hit_q) begin
      valid_d[hit_idx_q] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (addr_q == LastAddr) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (scanning) begin
      rd_data_q <= mem_q[addr_q[IdxW-1:0]];
    end
  end

  // request, match and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_e'(kind_i);
      key_low_q  <= norm_low;
      key_high_q <= norm_high;
      server_q   <= server_in_i;
    end
    if (scanning) begin
      ridx_q <= addr_q[IdxW-1:0];
    end
    if (ent_v && key_eq) begin
      hit_idx_q <= ridx_q;
      hit_srv_q <= rd_data_q.server;
    end
    if (rvalid_q && !valid_q[ridx_q] && !free_q) begin
      free_idx_q <= ridx_q;
    end
    if (fin_fire) begin
      status_q <= res_status;
      sout_q   <= res_server;
      rcount_q <= res_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      addr_q      <= '0;
      rvalid_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      rvalid_q <= scanning;
      if (accept) begin
        addr_q  <= '0;
        hit_q   <= 1'b0;
        free_q  <= 1'b0;
        count_q <= '0;
      end else begin
        if (scanning) begin
          addr_q <= addr_q + CntW'(1);
        end
        if (ent_v && key_eq) begin
          hit_q <= 1'b1;
        end
        if (rvalid_q && !valid_q[ridx_q]) begin
          free_q <= 1'b1;
        end
        if (ent_v && (kind_q == K_CLEANUP) && srv_eq && (count_q != CountMax)) begin
          count_q <= count_q + CountWidth'(1);
        end
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign server_out_o    = sout_q;
  assign removed_count_o = rcount_q;

`ifndef SYNTH
  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && (kind_q == K_INSERT) && (res_status == ST_OK))
      |=> valid_q[$past(free_idx_q)])
    else $error("insert did not mark its slot valid");

  a_remove_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && (kind_q == K_REMOVE) && (res_status == ST_OK))
      |=> !valid_q[$past(hit_idx_q)])
    else $error("remove left its entry valid");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result appeared outside the finish step");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= LastAddr))
    else $error("scan address ran past the table");
`endif

endmodule
`default_nettype wire
